// ----- rtl/pen_tablet_packet_decoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// pen tablet packet decoder assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef PEN_TABLET_PACKET_DECODER_UNIT_MACROS_SVH
`define PEN_TABLET_PACKET_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define PTPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ptpd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptpd_pkg
// types and constants of the pen tablet packet decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptpd_pkg;

	localparam int PACKET_BYTES = 8;
	localparam int STORE_DEPTH  = 7;
	localparam int IDX_W        = $clog2(PACKET_BYTES);

	localparam logic [7:0] START_LO   = 8'hA0;
	localparam logic [7:0] START_HI   = 8'hA5;
	localparam logic [7:0] PROX_LOST  = 8'h80;
	localparam logic [7:0] COORD_MASK = 8'h7F;

	localparam int POS_W  = 14;
	localparam int PRES_W = 9;

	// output beat layout, lowest bit first
	localparam int OUT_W       = 48;
	localparam int POS_X_LSB   = 0;
	localparam int POS_Y_LSB   = POS_X_LSB + POS_W;
	localparam int PRES_LSB    = POS_Y_LSB + POS_W;
	localparam int TOUCH_BIT   = PRES_LSB + PRES_W;
	localparam int BUTTON_BIT  = TOUCH_BIT + 1;
	localparam int HARD_BIT    = BUTTON_BIT + 1;
	localparam int ERASER_BIT  = HARD_BIT + 1;
	localparam int PEN_BIT     = ERASER_BIT + 1;
	localparam int USED_W      = PEN_BIT + 1;

	typedef logic [STORE_DEPTH-1:0][7:0] packet_t;

	typedef struct packed {
		logic    at_last;
		logic    fire;
		packet_t bytes;
	} coll_t;

	typedef struct packed {
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [PRES_W-1:0] tip_pressure;
		logic              touching;
		logic              side_button;
		logic              hard_press;
		logic              eraser_tool;
		logic              pen_tool;
	} result_t;

	function automatic logic is_start(input logic [7:0] b);
		is_start = ((b >= START_LO) && (b <= START_HI)) || (b == PROX_LOST);
	endfunction

endpackage

// ----- rtl/ptpd_collect.sv -----
// ----------------------------------------------------------------------------
// ptpd_collect
// start byte hunt, byte counting and packet byte store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptpd_collect (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     rx_byte,
	output ptpd_pkg::coll_t coll
);
	import ptpd_pkg::*;

	logic             in_packet_q;
	logic [IDX_W-1:0] idx_q;
	packet_t          store_q;
	logic             at_last;
	logic             start;

	assign at_last = in_packet_q && (idx_q == IDX_W'(PACKET_BYTES - 1));
	assign start   = is_start(rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			idx_q       <= '0;
		end else if (take) begin
			if (!in_packet_q) begin
				if (start) begin
					in_packet_q <= 1'b1;
					idx_q       <= IDX_W'(1);
				end
			end else if (at_last) begin
				in_packet_q <= 1'b0;
				idx_q       <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (!in_packet_q) begin
				if (start) begin
					store_q[0] <= rx_byte;
				end
			end else begin
				for (int i = 1; i < STORE_DEPTH; i++) begin
					if (idx_q == IDX_W'(i)) begin
						store_q[i] <= rx_byte;
					end
				end
			end
		end
	end

	// bypass the current byte when its index still lands in the store
	always_comb begin
		coll.bytes = store_q;
		for (int i = 1; i < STORE_DEPTH; i++) begin
			if (idx_q == IDX_W'(i)) begin
				coll.bytes[i] = rx_byte;
			end
		end
		coll.at_last = at_last;
		coll.fire    = take && at_last;
	end

endmodule

// ----- rtl/ptpd_decode.sv -----
// ----------------------------------------------------------------------------
// ptpd_decode
// field decode of one complete packet
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptpd_decode (
	input  ptpd_pkg::packet_t bytes,
	output ptpd_pkg::result_t res
);
	import ptpd_pkg::*;

	logic [7:0] b0;
	logic       hard;
	logic       lost;

	assign b0   = bytes[0];
	assign hard = bytes[6][0];
	assign lost = (b0 == PROX_LOST);

	assign res.pos_x        = {7'(bytes[1] & COORD_MASK), 7'(bytes[2] & COORD_MASK)};
	assign res.pos_y        = {7'(bytes[3] & COORD_MASK), 7'(bytes[4] & COORD_MASK)};
	assign res.tip_pressure = PRES_W'(bytes[5]) + {1'b0, hard, 7'b0};
	assign res.touching     = b0[0];
	assign res.side_button  = b0[1];
	assign res.hard_press   = hard;
	assign res.eraser_tool  = b0[2] && !lost;
	assign res.pen_tool     = !b0[2] && !lost;

endmodule

// ----- rtl/pen_tablet_packet_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// pen_tablet_packet_decoder_unit
// hunts serial digitizer bytes for a start byte and decodes each packet
// into one position, pressure and tool report
// ----------------------------------------------------------------------------
//  channel  dir  beat                   tlast  tuser
//  s_axis   in   one serial byte        -      -
//  m_axis   out  one decoded report     -      -
//
//  one byte per cycle unless stalled; a report is valid the cycle after the last packet byte
//  the packet store and counter form the input register, the report register
//  is the output register
//  only the last byte of a packet waits on a full, stalled report register
//  arst_n clears the hunt state and the report valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pen_tablet_packet_decoder_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,  // rx_byte
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// pos_x, pos_y, tip_pressure, touching, side_button, hard_press,
	// eraser_tool, pen_tool, zero fill
	output logic [ptpd_pkg::OUT_W-1:0] m_axis_tdata
);
	import ptpd_pkg::*;

	coll_t   coll;
	result_t res;
	result_t res_q;
	logic    out_vld_q;
	logic    take;

	assign s_axis_tready = !coll.at_last || !out_vld_q || m_axis_tready;
	assign take          = s_axis_tvalid && s_axis_tready;

	ptpd_collect u_collect (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (s_axis_tdata),
		.coll    (coll)
	);

	ptpd_decode u_decode (
		.bytes (coll.bytes),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (coll.fire) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (coll.fire) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;

	always_comb begin
		m_axis_tdata                                = '0;
		m_axis_tdata[POS_X_LSB +: POS_W]            = res_q.pos_x;
		m_axis_tdata[POS_Y_LSB +: POS_W]            = res_q.pos_y;
		m_axis_tdata[PRES_LSB +: PRES_W]            = res_q.tip_pressure;
		m_axis_tdata[TOUCH_BIT]                     = res_q.touching;
		m_axis_tdata[BUTTON_BIT]                    = res_q.side_button;
		m_axis_tdata[HARD_BIT]                      = res_q.hard_press;
		m_axis_tdata[ERASER_BIT]                    = res_q.eraser_tool;
		m_axis_tdata[PEN_BIT]                       = res_q.pen_tool;
	end

endmodule

// ----- rtl/ptpd_checker.sv -----
// ----------------------------------------------------------------------------
// ptpd_checker
// port-level checks on the pen tablet packet decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pen_tablet_packet_decoder_unit_macros.svh"

module ptpd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [ptpd_pkg::OUT_W-1:0] m_axis_tdata
);
	import ptpd_pkg::*;

	logic in_beat;

	assign in_beat = s_axis_tvalid && s_axis_tready;

	`PTPD_ASSERT_NEXT(a_out_held, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid, "report dropped while stalled")

	`PTPD_ASSERT_IMPLY(a_tool_excl, clk, arst_n, m_axis_tvalid,
		!(m_axis_tdata[ERASER_BIT] && m_axis_tdata[PEN_BIT]), "eraser and pen both set")

	`PTPD_ASSERT_IMPLY(a_soft_pres, clk, arst_n, m_axis_tvalid && !m_axis_tdata[HARD_BIT],
		!m_axis_tdata[PRES_LSB + PRES_W - 1], "pressure above 255 without hard press")

	`PTPD_ASSERT_IMPLY(a_rise_src, clk, arst_n, $rose(m_axis_tvalid), $past(in_beat),
		"report without a byte beat")

	`PTPD_ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[OUT_W-1:USED_W] == '0, "fill bits not zero")

endmodule

bind pen_tablet_packet_decoder_unit ptpd_checker u_ptpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- dv/pen_tablet_packet_decoder_unit_tb.sv -----
// ----------------------------------------------------------------------------
// pen_tablet_packet_decoder_unit_tb
// feeds serial digitizer bytes through the s_axis port and checks every
// decoded report on m_axis against a packet decoder written in the bench;
// a short table of directed bytes comes first, then random packets mixed
// with noise, truncated packets and random gaps and stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pen_tablet_packet_decoder_unit_tb;

	import ptpd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BYTES = 800;
	localparam int MAX_WAIT     = 17;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0] rx_byte;
		bit         typed;
		result_t    report;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	// decoder state in the bench
	bit                hunting_done;
	int unsigned       pkt_pos;
	logic [7:0]        pkt_bytes [STORE_DEPTH];

	result_t           report_q [$];
	stim_row_t         stim_table [$];
	int                error_count;
	int                cycle_count;
	bit                tx_burst;
	bit                rx_burst;

	pen_tablet_packet_decoder_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit is_sync_byte(input logic [7:0] b);
		return (b >= START_LO && b <= START_HI) || b == PROX_LOST;
	endfunction

	function automatic result_t make_report(input int x, input int y, input int pres,
			input bit touch, input bit button, input bit hard, input bit eraser,
			input bit pen);
		result_t r;
		r.pos_x        = x[POS_W-1:0];
		r.pos_y        = y[POS_W-1:0];
		r.tip_pressure = pres[PRES_W-1:0];
		r.touching     = touch;
		r.side_button  = button;
		r.hard_press   = hard;
		r.eraser_tool  = eraser;
		r.pen_tool     = pen;
		return r;
	endfunction

	// advances the bench decoder by one byte; returns 1 when a report is due
	function automatic bit decode_rx_byte(input logic [7:0] b, output result_t r);
		logic [7:0] head;
		bit         eraser;
		bit         hard;
		r = '0;
		if (!hunting_done) begin
			if (is_sync_byte(b)) begin
				pkt_bytes[0] = b;
				hunting_done = 1'b1;
				pkt_pos = 1;
			end
			return 1'b0;
		end
		if (pkt_pos < STORE_DEPTH)
			pkt_bytes[pkt_pos] = b;
		if (pkt_pos + 1 < PACKET_BYTES) begin
			pkt_pos++;
			return 1'b0;
		end
		head = pkt_bytes[0];
		hard = pkt_bytes[6][0];
		eraser = head[2];
		r.pos_x = {pkt_bytes[1][6:0], pkt_bytes[2][6:0]};
		r.pos_y = {pkt_bytes[3][6:0], pkt_bytes[4][6:0]};
		r.tip_pressure = {1'b0, pkt_bytes[5]} + (hard ? 9'd128 : 9'd0);
		r.touching = head[0];
		r.side_button = head[1];
		r.hard_press = hard;
		r.eraser_tool = (head == PROX_LOST) ? 1'b0 : eraser;
		r.pen_tool = (head == PROX_LOST) ? 1'b0 : !eraser;
		hunting_done = 1'b0;
		pkt_pos = 0;
		return 1'b1;
	endfunction

	task automatic report_error(input string msg);
		$display("[%0t] error: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_error($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic send_byte(input logic [7:0] b, input bit typed, input result_t typed_r);
		int      gap;
		result_t r;
		bit      due;
		gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		due = decode_rx_byte(b, r);
		if (typed) begin
			if (!due)
				report_error("directed row expects a report the decoder does not give");
			report_q.push_back(typed_r);
		end else if (due) begin
			report_q.push_back(r);
		end
	endtask

	task automatic send_plain(input logic [7:0] b);
		send_byte(b, 1'b0, '0);
	endtask

	task automatic add_row(input logic [7:0] b);
		stim_row_t row;
		row.rx_byte = b;
		row.typed = 1'b0;
		row.report = '0;
		stim_table.push_back(row);
	endtask

	task automatic add_last_row(input logic [7:0] b, input result_t r);
		stim_row_t row;
		row.rx_byte = b;
		row.typed = 1'b1;
		row.report = r;
		stim_table.push_back(row);
	endtask

	task automatic wait_for_reports;
		while (report_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] draw_sync_byte;
		int n;
		n = $urandom_range(0, 6);
		return (n == 6) ? PROX_LOST : START_LO + 8'(n);
	endfunction

	// output side: random stall before each beat
	initial begin
		int stall;
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
			repeat (stall) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (report_q.size() == 0) begin
				report_error("report beat with none expected");
			end else begin
				want = report_q.pop_front();
				check_field("pos_x", int'(m_axis_tdata[POS_X_LSB +: POS_W]),
					int'(want.pos_x));
				check_field("pos_y", int'(m_axis_tdata[POS_Y_LSB +: POS_W]),
					int'(want.pos_y));
				check_field("tip_pressure", int'(m_axis_tdata[PRES_LSB +: PRES_W]),
					int'(want.tip_pressure));
				check_field("touching", int'(m_axis_tdata[TOUCH_BIT]),
					int'(want.touching));
				check_field("side_button", int'(m_axis_tdata[BUTTON_BIT]),
					int'(want.side_button));
				check_field("hard_press", int'(m_axis_tdata[HARD_BIT]),
					int'(want.hard_press));
				check_field("eraser_tool", int'(m_axis_tdata[ERASER_BIT]),
					int'(want.eraser_tool));
				check_field("pen_tool", int'(m_axis_tdata[PEN_BIT]),
					int'(want.pen_tool));
				check_field("zero fill", int'(m_axis_tdata[OUT_W-1:USED_W]), 0);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("pen_tablet_packet_decoder_unit_tb NOT OK");
		$finish;
	end

	initial begin
		int          sent;
		int          pkt_len;
		int          packets;
		logic [7:0]  b;
		hunting_done = 1'b0;
		pkt_pos = 0;
		foreach (pkt_bytes[i])
			pkt_bytes[i] = '0;

		// noise while hunting, then all-ones packet, then proximity lost
		// with a sync byte inside the packet
		add_row(8'h00);
		add_row(8'h7F);
		add_row(8'h9F);
		add_row(8'hA6);
		add_row(8'hFF);
		add_row(8'h81);
		add_row(8'hA5);
		repeat (6) add_row(8'hFF);
		add_last_row(8'hFF, make_report(16383, 16383, 383, 1, 0, 1, 1, 0));
		add_row(PROX_LOST);
		add_row(8'hA0);
		repeat (4) add_row(8'h00);
		add_row(8'hFE);
		add_last_row(8'hFF, make_report(4096, 0, 0, 0, 0, 0, 0, 0));
		add_row(8'hA3);
		repeat (7) add_row(8'($urandom_range(0, 255)));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i])
			send_byte(stim_table[i].rx_byte, stim_table[i].typed, stim_table[i].report);

		sent = 0;
		packets = 0;
		while (sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 7) == 0)
				tx_burst = !tx_burst;
			if (packets == 40) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				wait_for_reports();
			end
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3))
					send_plain(8'($urandom_range(0, 255)));
			end
			// mostly full packets, a few cut short
			pkt_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PACKET_BYTES - 1)
				: PACKET_BYTES;
			send_plain(draw_sync_byte());
			for (int k = 1; k < pkt_len; k++) begin
				b = ($urandom_range(0, 7) == 0) ? draw_sync_byte()
					: 8'($urandom_range(0, 255));
				send_plain(b);
			end
			sent += pkt_len;
			packets++;
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_for_reports();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (report_q.size() != 0)
			report_error($sformatf("%0d reports never arrived", report_q.size()));
		if (error_count == 0)
			$display("pen_tablet_packet_decoder_unit_tb OK");
		else
			$display("pen_tablet_packet_decoder_unit_tb NOT OK");
		$finish;
	end

endmodule
